[rtl/glpd_pkg.sv]
// shared types, widths and register codes of the grid local peak detector
package glpd_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int SAMPLE_W   = 32;
    localparam int CFG_W      = 11;
    localparam int POS_W      = 11;
    localparam int COUNT_W    = 21;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] TOTAL_MAX = '1;

    localparam logic REG_GRID_COLS = 1'b0;
    localparam logic REG_GRID_ROWS = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       pad;
    } t_in_item;

    typedef struct packed {
        logic               is_total;
        logic [POS_W-1:0]   peak_row;
        logic [POS_W-1:0]   peak_col;
        logic [COUNT_W-1:0] total_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic             peak;
        logic             total;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_decision;

endpackage

[rtl/glpd_ifs.sv]
// valid/ready stream interfaces for sample input and result output
interface glpd_in_if;
    import glpd_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface glpd_out_if;
    import glpd_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/grid_local_peak_detector.sv]
// top level of the strict four-neighbour grid local peak detector
//
//  channel      dir  handshake               payload
//  i_sample_if  in   valid/ready             sample, pad
//  o_peak_if    out  valid/ready             is_total, peak_row, peak_col, total_count, last
//  apb          in   psel/penable/pwrite     paddr, pwdata, prdata (grid_cols, grid_rows)
//
// one sample per cycle sustained when the output does not stall; each bank ram gives
// one read a cycle and the window shifts one column per accepted item
// a cell is decided in the cycle after the sample below it (or its pad) is taken
// the final pad that also finds a peak holds the input while peak then total are loaded
// pads sent before the grid is complete are taken and dropped
// reset clears counters and control only; the line rams need no clearing pass
// an output stall holds the decision stage, which backs up into i_sample_if.ready
module grid_local_peak_detector #(
    parameter int MAX_COLS = glpd_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = glpd_pkg::MAX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [glpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [glpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [glpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    glpd_in_if.sink                         i_sample_if,
    glpd_out_if.source                      o_peak_if
);
    import glpd_pkg::*;

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic          restart;
    logic [CW-1:0] cols;
    logic [RW-1:0] rows;
    logic          dec_valid;
    t_decision     dec;
    logic          dec_retire;

    glpd_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_restart (restart),
        .o_cols    (cols),
        .o_rows    (rows)
    );

    glpd_window #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_cols       (cols),
        .i_rows       (rows),
        .i_sample_if  (i_sample_if),
        .o_dec_valid  (dec_valid),
        .o_dec        (dec),
        .i_dec_retire (dec_retire)
    );

    glpd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_dec_valid (dec_valid),
        .i_dec       (dec),
        .o_retire    (dec_retire),
        .o_peak_if   (o_peak_if)
    );
endmodule

[rtl/glpd_ram.sv]
// generic simple dual port ram with registered read
module glpd_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/glpd_cfg.sv]
// apb register block for grid size, with clamping and restart pulse
module glpd_cfg #(
    parameter int  MAX_COLS = glpd_pkg::MAX_COLS_DEF,
    parameter int  MAX_ROWS = glpd_pkg::MAX_ROWS_DEF,
    localparam int CW       = $clog2(MAX_COLS + 1),
    localparam int RW       = $clog2(MAX_ROWS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [glpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [glpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [glpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic                            o_restart,
    output logic [CW-1:0]                   o_cols,
    output logic [RW-1:0]                   o_rows
);
    import glpd_pkg::*;

    logic [CFG_W-1:0] r_cols;
    logic [CFG_W-1:0] r_rows;
    logic             wr;
    logic             idx;

    assign pready = 1'b1;
    assign idx    = paddr[2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_W'(1);
            r_rows <= CFG_W'(1);
        end else if (wr) begin
            case (idx)
                REG_GRID_COLS: r_cols <= pwdata[CFG_W-1:0];
                REG_GRID_ROWS: r_rows <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GRID_COLS: prdata = APB_DATA_W'(r_cols);
            REG_GRID_ROWS: prdata = APB_DATA_W'(r_rows);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        if (r_cols == '0) begin
            o_cols = CW'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            o_cols = CW'(MAX_COLS);
        end else begin
            o_cols = CW'(r_cols);
        end
        if (r_rows == '0) begin
            o_rows = RW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            o_rows = RW'(MAX_ROWS);
        end else begin
            o_rows = RW'(r_rows);
        end
    end

    assign o_restart = wr;
endmodule

[rtl/glpd_window.sv]
// raster counters, two banked line rams, 3-wide window and neighbour compare
module glpd_window #(
    parameter int  MAX_COLS = glpd_pkg::MAX_COLS_DEF,
    parameter int  MAX_ROWS = glpd_pkg::MAX_ROWS_DEF,
    localparam int CW       = $clog2(MAX_COLS + 1),
    localparam int RW       = $clog2(MAX_ROWS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic [CW-1:0]       i_cols,
    input  logic [RW-1:0]       i_rows,
    glpd_in_if.sink             i_sample_if,
    output logic                o_dec_valid,
    output glpd_pkg::t_decision o_dec,
    input  logic                i_dec_retire
);
    import glpd_pkg::*;

    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [RW-1:0]  r_row, n_row;
    logic [CIW-1:0] r_col, n_col;
    logic [CW-1:0]  col_next;
    logic [CIW-1:0] right_addr;
    logic           has_right;
    logic           flush;
    logic           in_ready;
    logic           accept;
    logic           active;
    logic           decide;
    logic           peak;

    logic signed [SAMPLE_W-1:0] key;
    logic signed [SAMPLE_W-1:0] up_val;
    logic signed [SAMPLE_W-1:0] right_val;

    logic [1:0]          we;
    logic [CIW-1:0]      raddr   [2];
    logic [SAMPLE_W-1:0] rd_data [2];

    logic                       r_s1_valid;
    logic                       r_has_left;
    logic                       r_has_right;
    logic                       r_has_up;
    logic                       r_has_down;
    logic                       r_total_flag;
    logic                       r_up_bank;
    logic [POS_W-1:0]           r_row_out;
    logic [POS_W-1:0]           r_col_out;
    logic signed [SAMPLE_W-1:0] r_down;
    logic signed [SAMPLE_W-1:0] r_left;
    logic signed [SAMPLE_W-1:0] r_center;
    logic signed [SAMPLE_W-1:0] r_first;

    assign key        = i_sample_if.data.sample;
    assign col_next   = CW'(r_col) + CW'(1);
    assign has_right  = col_next < i_cols;
    assign right_addr = has_right ? col_next[CIW-1:0] : '0;
    assign flush      = !(r_row < i_rows);
    assign in_ready   = !r_s1_valid || i_dec_retire;
    assign accept     = i_sample_if.valid && in_ready;
    assign active     = accept && (flush || !i_sample_if.data.pad);
    assign decide     = flush || (r_row != '0);

    assign i_sample_if.ready = in_ready;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_restart) begin
            n_row = '0;
            n_col = '0;
        end else if (active) begin
            if (has_right) begin
                n_col = col_next[CIW-1:0];
            end else begin
                n_col = '0;
                if (flush) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // bank of the current row is read for up and written, the other bank gives right
    for (genvar b = 0; b < 2; b++) begin : g_bank
        assign we[b]    = active && !flush && (r_row[0] == 1'(b));
        assign raddr[b] = (r_row[0] == 1'(b)) ? r_col : right_addr;

        glpd_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (MAX_COLS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we[b]),
            .i_waddr (r_col),
            .i_wdata (key),
            .i_re    (active),
            .i_raddr (raddr[b]),
            .o_rdata (rd_data[b])
        );
    end

    assign up_val    = $signed(r_up_bank ? rd_data[1] : rd_data[0]);
    assign right_val = $signed(r_up_bank ? rd_data[0] : rd_data[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_restart) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= active && decide;
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            r_has_left   <= r_col != '0;
            r_has_right  <= has_right;
            r_has_up     <= 32'(r_row) > 1;
            r_has_down   <= !flush;
            r_total_flag <= flush && !has_right;
            r_up_bank    <= r_row[0];
            r_row_out    <= POS_W'(r_row);
            r_col_out    <= POS_W'(col_next);
            r_down       <= key;
            r_left       <= r_center;
            r_center     <= (r_col == '0) ? r_first : right_val;
            if (!flush && r_col == '0) begin
                r_first <= key;
            end
        end
    end

    assign peak = (!r_has_left  || r_center > r_left)
               && (!r_has_right || r_center > right_val)
               && (!r_has_up    || r_center > up_val)
               && (!r_has_down  || r_center > r_down);

    assign o_dec_valid = r_s1_valid;
    assign o_dec.peak  = peak;
    assign o_dec.total = r_total_flag;
    assign o_dec.row   = r_row_out;
    assign o_dec.col   = r_col_out;

`ifndef SYNTHESIS
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < i_cols)
        else $error("column counter beyond grid width");

    a_dec_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !i_dec_retire && !i_restart |=> r_s1_valid && $stable(r_down)
            && $stable(r_center))
        else $error("stalled decision overwritten");
`endif
endmodule

[rtl/glpd_emit.sv]
// result sequencing into the output register and saturating peak total
module glpd_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic                i_dec_valid,
    input  glpd_pkg::t_decision i_dec,
    output logic                o_retire,
    glpd_out_if.source          o_peak_if
);
    import glpd_pkg::*;

    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_item;
    logic               r_phase, n_phase;
    logic [COUNT_W-1:0] r_total;
    logic               out_free;
    logic               load;
    logic               count_inc;
    logic               count_clear;

    assign out_free = !r_out_valid || o_peak_if.ready;

    always_comb begin
        o_retire    = 1'b0;
        load        = 1'b0;
        n_phase     = r_phase;
        n_item      = '0;
        count_inc   = 1'b0;
        count_clear = 1'b0;
        if (i_dec_valid) begin
            if (!i_dec.peak && !i_dec.total) begin
                o_retire = 1'b1;
            end else if (out_free) begin
                load = 1'b1;
                if (i_dec.peak && !r_phase) begin
                    n_item.peak_row = i_dec.row;
                    n_item.peak_col = i_dec.col;
                    n_item.last     = !i_dec.total;
                    count_inc       = 1'b1;
                    if (i_dec.total) begin
                        n_phase = 1'b1;
                    end else begin
                        o_retire = 1'b1;
                    end
                end else begin
                    n_item.is_total    = 1'b1;
                    n_item.total_count = r_total;
                    n_item.last        = 1'b1;
                    o_retire           = 1'b1;
                    n_phase            = 1'b0;
                    count_clear        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_total     <= '0;
        end else if (i_restart) begin
            r_out_valid <= load || (r_out_valid && !o_peak_if.ready);
            r_phase     <= 1'b0;
            r_total     <= '0;
        end else begin
            r_out_valid <= load || (r_out_valid && !o_peak_if.ready);
            r_phase     <= n_phase;
            if (count_clear) begin
                r_total <= '0;
            end else if (count_inc && r_total != TOTAL_MAX) begin
                r_total <= r_total + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_item;
        end
    end

    assign o_peak_if.valid = r_out_valid;
    assign o_peak_if.data  = r_out;

`ifndef SYNTHESIS
    a_phase_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_dec_valid && i_dec.peak && i_dec.total)
        else $error("second result pending without a peak and total decision");

    a_total_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_total |-> r_out.last)
        else $error("total result not marked last");
`endif
endmodule
